>>> hw/rtl/rc4_pkg.sv
// rc4 engine shared types, constants and command codes
package rc4_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned SBOX_DEPTH  = 256;
   localparam int unsigned SBOX_AW     = $clog2(SBOX_DEPTH);
   localparam int unsigned KEY_MAX_DEF = 256;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PW    = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_DATA = 1'b1;

   typedef enum logic [1:0] {
      CMD_KEY,
      CMD_KEY_LAST,
      CMD_DATA,
      CMD_DATA_NEW
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [BYTE_W-1:0]  data;
   } cmd_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_D1,
      B_D2,
      B_D3,
      B_INIT,
      B_R0,
      B_R1,
      B_R2,
      B_R3
   } back_state_type;

endpackage

>>> hw/rtl/rc4_req_if.sv
// request channel: key and data bytes into the engine
interface rc4_req_if;
   logic                       valid;
   logic                       ready;
   logic                       op;
   logic [rc4_pkg::BYTE_W-1:0] in_byte;
   logic                       last_key;
   logic                       new_message;

   modport source (output valid, output op, output in_byte, output last_key,
                   output new_message, input ready);
   modport sink   (input valid, input op, input in_byte, input last_key,
                   input new_message, output ready);
endinterface

>>> hw/rtl/rc4_rsp_if.sv
// response channel: processed data bytes out of the engine
interface rc4_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [rc4_pkg::BYTE_W-1:0] out_byte;

   modport source (output valid, output out_byte, input ready);
   modport sink   (input valid, input out_byte, output ready);
endinterface

>>> hw/rtl/rc4_ram.sv
// generic single write port, single read port ram with registered read
module rc4_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/rc4_front.sv
// front end: accepts request beats, classifies them and queues commands
module rc4_front (
   input  logic              clock,
   input  logic              reset,
   rc4_req_if.sink           req_bus,
   output logic              q_valid,
   output rc4_pkg::cmd_type  q_cmd,
   input  logic              q_pop
);

   rc4_pkg::cmd_type                  q_mem_ff [rc4_pkg::QUEUE_DEPTH];
   logic [rc4_pkg::QUEUE_PW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [rc4_pkg::QUEUE_PW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [rc4_pkg::QUEUE_CW-1:0]      cnt_ff, cnt_in;
   logic                              push;
   rc4_pkg::cmd_type                  new_cmd;

   always_comb begin
      new_cmd.data = req_bus.in_byte;
      if (req_bus.op == rc4_pkg::OP_DATA) begin
         new_cmd.kind = req_bus.new_message ? rc4_pkg::CMD_DATA_NEW : rc4_pkg::CMD_DATA;
      end else begin
         new_cmd.kind = req_bus.last_key ? rc4_pkg::CMD_KEY_LAST : rc4_pkg::CMD_KEY;
      end
   end

   assign req_bus.ready = (cnt_ff != rc4_pkg::QUEUE_CW'(rc4_pkg::QUEUE_DEPTH));
   assign push          = req_bus.valid & req_bus.ready;
   assign q_valid       = (cnt_ff != '0);
   assign q_cmd         = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? rc4_pkg::QUEUE_PW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? rc4_pkg::QUEUE_PW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !q_pop) begin
         cnt_in = rc4_pkg::QUEUE_CW'(cnt_ff + 1'b1);
      end else if (!push && q_pop) begin
         cnt_in = rc4_pkg::QUEUE_CW'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= new_cmd;
      end
   end

`ifndef NO_ASSERTIONS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= rc4_pkg::QUEUE_CW'(rc4_pkg::QUEUE_DEPTH))
      else $error("command queue overfilled");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (cnt_ff != '0))
      else $error("pop from empty command queue");
`endif

endmodule

>>> hw/rtl/rc4_back.sv
// back end: key store, key schedule and keystream steps over the s-box ram
module rc4_back #(
   parameter int unsigned KEY_MAX = rc4_pkg::KEY_MAX_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  rc4_pkg::cmd_type  q_cmd,
   output logic              q_pop,
   rc4_rsp_if.source         rsp_bus
);

   localparam int unsigned CW     = $clog2(KEY_MAX + 1);
   localparam int unsigned KEY_AW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
   localparam logic [CW-1:0] KeyMaxC = CW'(KEY_MAX);
   localparam int unsigned BW = rc4_pkg::BYTE_W;
   localparam int unsigned AW = rc4_pkg::SBOX_AW;

   rc4_pkg::back_state_type state_ff, state_in;

   logic [AW-1:0]  i_ff, i_in;
   logic [AW-1:0]  j_ff, j_in;
   logic [BW-1:0]  si_ff, si_in;
   logic [AW-1:0]  t_ff, t_in;
   logic [BW-1:0]  byte_ff, byte_in;
   logic [CW-1:0]  key_count_ff, key_count_in;
   logic [CW-1:0]  kidx_ff, kidx_in;
   logic [AW-1:0]  n_ff, n_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0]  rsp_byte_ff, rsp_byte_in;

   // s-box storage: ram plus per-entry valid bits, invalid entry reads as its index
   logic [rc4_pkg::SBOX_DEPTH-1:0] sbox_vld_ff, sbox_vld_in;
   logic           vld_q_ff;
   logic [AW-1:0]  raddr_q_ff;
   logic           byp_ff;
   logic [BW-1:0]  byp_data_ff;

   logic           sbox_we;
   logic [AW-1:0]  sbox_waddr;
   logic [BW-1:0]  sbox_wdata;
   logic [AW-1:0]  sbox_raddr;
   logic [BW-1:0]  sbox_rdata;
   logic [BW-1:0]  sbox_rd;

   logic           key_we;
   logic [BW-1:0]  key_rdata;

   logic           out_free;
   logic           can_disp;
   logic           disp;
   logic           disp_data;
   logic [AW-1:0]  ii_n;
   logic [AW-1:0]  jn;
   logic           sched_done;
   rc4_pkg::back_state_type disp_state;

   rc4_ram #(.WIDTH(BW), .DEPTH(rc4_pkg::SBOX_DEPTH)) u_sbox_ram (
      .clock (clock),
      .we    (sbox_we),
      .waddr (sbox_waddr),
      .wdata (sbox_wdata),
      .raddr (sbox_raddr),
      .rdata (sbox_rdata)
   );

   rc4_ram #(.WIDTH(BW), .DEPTH(KEY_MAX)) u_key_ram (
      .clock (clock),
      .we    (key_we),
      .waddr (key_count_ff[KEY_AW-1:0]),
      .wdata (q_cmd.data),
      .raddr (kidx_ff[KEY_AW-1:0]),
      .rdata (key_rdata)
   );

   assign sbox_rd = byp_ff ? byp_data_ff : (vld_q_ff ? sbox_rdata : raddr_q_ff);

   assign out_free   = !rsp_valid_ff || rsp_bus.ready;
   assign can_disp   = (state_ff == rc4_pkg::B_IDLE) ||
                       ((state_ff == rc4_pkg::B_D3) && out_free);
   assign disp       = can_disp && q_valid;
   assign disp_data  = q_cmd.kind inside {rc4_pkg::CMD_DATA, rc4_pkg::CMD_DATA_NEW};
   assign q_pop      = disp;
   assign ii_n       = ((q_cmd.kind == rc4_pkg::CMD_DATA_NEW) ? '0 : i_ff) + 1'b1;
   assign jn         = j_ff + sbox_rd + key_rdata;
   assign sched_done = (n_ff == AW'(rc4_pkg::SBOX_DEPTH - 1));

   always_comb begin
      disp_state = rc4_pkg::B_IDLE;
      if (disp_data) begin
         disp_state = rc4_pkg::B_D1;
      end else if (q_cmd.kind == rc4_pkg::CMD_KEY_LAST) begin
         disp_state = rc4_pkg::B_INIT;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rc4_pkg::B_IDLE: begin
            if (disp) begin
               state_in = disp_state;
            end
         end
         rc4_pkg::B_D1:   state_in = rc4_pkg::B_D2;
         rc4_pkg::B_D2:   state_in = rc4_pkg::B_D3;
         rc4_pkg::B_D3: begin
            if (out_free) begin
               state_in = disp ? disp_state : rc4_pkg::B_IDLE;
            end
         end
         rc4_pkg::B_INIT: state_in = rc4_pkg::B_R0;
         rc4_pkg::B_R0:   state_in = rc4_pkg::B_R1;
         rc4_pkg::B_R1:   state_in = rc4_pkg::B_R2;
         rc4_pkg::B_R2:   state_in = rc4_pkg::B_R3;
         rc4_pkg::B_R3:   state_in = sched_done ? rc4_pkg::B_IDLE : rc4_pkg::B_R0;
         default:         state_in = rc4_pkg::B_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      i_in         = i_ff;
      j_in         = j_ff;
      si_in        = si_ff;
      t_in         = t_ff;
      byte_in      = byte_ff;
      key_count_in = key_count_ff;
      kidx_in      = kidx_ff;
      n_in         = n_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      sbox_we      = 1'b0;
      sbox_waddr   = j_ff;
      sbox_wdata   = si_ff;
      sbox_raddr   = t_ff;
      key_we       = 1'b0;

      if (disp) begin
         if (disp_data) begin
            i_in       = ii_n;
            j_in       = (q_cmd.kind == rc4_pkg::CMD_DATA_NEW) ? '0 : j_ff;
            byte_in    = q_cmd.data;
            sbox_raddr = ii_n;
         end else if (key_count_ff < KeyMaxC) begin
            key_we       = 1'b1;
            key_count_in = CW'(key_count_ff + 1'b1);
         end
      end

      case (state_ff)
         rc4_pkg::B_D1: begin
            si_in      = sbox_rd;
            j_in       = j_ff + sbox_rd;
            sbox_raddr = j_ff + sbox_rd;
         end
         rc4_pkg::B_D2: begin
            // s[i] takes old s[j]; read s[s_i + s_j] alongside
            sbox_we    = 1'b1;
            sbox_waddr = i_ff;
            sbox_wdata = sbox_rd;
            t_in       = si_ff + sbox_rd;
            sbox_raddr = si_ff + sbox_rd;
         end
         rc4_pkg::B_D3: begin
            sbox_we    = 1'b1;
            sbox_waddr = j_ff;
            sbox_wdata = si_ff;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               // s[j] is only written this cycle, so its new value is s_i
               rsp_byte_in  = byte_ff ^ ((t_ff == j_ff) ? si_ff : sbox_rd);
            end
         end
         rc4_pkg::B_INIT: begin
            j_in    = '0;
            n_in    = '0;
            kidx_in = '0;
         end
         rc4_pkg::B_R0: begin
            sbox_raddr = n_ff;
         end
         rc4_pkg::B_R1: begin
            si_in      = sbox_rd;
            j_in       = jn;
            sbox_raddr = jn;
         end
         rc4_pkg::B_R2: begin
            sbox_we    = 1'b1;
            sbox_waddr = n_ff;
            sbox_wdata = sbox_rd;
         end
         rc4_pkg::B_R3: begin
            sbox_we    = 1'b1;
            sbox_waddr = j_ff;
            sbox_wdata = si_ff;
            n_in       = AW'(n_ff + 1'b1);
            kidx_in    = (CW'(kidx_ff + 1'b1) == key_count_ff) ? '0 : CW'(kidx_ff + 1'b1);
            if (sched_done) begin
               key_count_in = '0;
               i_in         = '0;
               j_in         = '0;
            end
         end
         default: begin
         end
      endcase

      sbox_vld_in = sbox_vld_ff;
      if (state_ff == rc4_pkg::B_INIT) begin
         sbox_vld_in = '0;
      end else if (sbox_we) begin
         sbox_vld_in[sbox_waddr] = 1'b1;
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.out_byte = rsp_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rc4_pkg::B_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         key_count_ff <= '0;
         kidx_ff      <= '0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         sbox_vld_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         key_count_ff <= key_count_in;
         kidx_ff      <= kidx_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
         sbox_vld_ff  <= sbox_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      si_ff       <= si_in;
      t_ff        <= t_in;
      byte_ff     <= byte_in;
      rsp_byte_ff <= rsp_byte_in;
      vld_q_ff    <= sbox_vld_ff[sbox_raddr];
      raddr_q_ff  <= sbox_raddr;
      byp_ff      <= sbox_we && (sbox_waddr == sbox_raddr);
      byp_data_ff <= sbox_wdata;
   end

`ifndef NO_ASSERTIONS
   a_init_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rc4_pkg::B_INIT) |=> (sbox_vld_ff == '0))
      else $error("s-box valid bits not cleared at schedule start");
   a_key_bound: assert property (@(posedge clock) disable iff (reset)
      key_count_ff <= KeyMaxC)
      else $error("key count past limit");
   a_sched_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rc4_pkg::B_R3) && sched_done |=>
         (key_count_ff == '0) && (i_ff == '0) && (j_ff == '0))
      else $error("indices not cleared after key schedule");
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> ((state_ff == rc4_pkg::B_IDLE) || (state_ff == rc4_pkg::B_D3)))
      else $error("command taken while engine busy");
`endif

endmodule

>>> hw/rtl/rc4_stream_cipher_core.sv
// data byte: accepted in idle, or in D3 when the output is free (read s[i], read s[j],
// read s[s_i + s_j] with the swap writes) on the s-box ram; response registered in D3
// key byte: final key byte adds the schedule, INIT then R0-R3 for every s-box entry
// reset: synchronous, s-box reads as identity at once through per-entry valid bits,
// key count and indices cleared, queue and response register emptied
module rc4_stream_cipher_core #(
   parameter int unsigned KEY_MAX = rc4_pkg::KEY_MAX_DEF
) (
   input  logic      clock,
   input  logic      reset,
   rc4_req_if.sink   req_bus,
   rc4_rsp_if.source rsp_bus
);

   logic             q_valid;
   rc4_pkg::cmd_type q_cmd;
   logic             q_pop;

   rc4_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_valid (q_valid),
      .q_cmd   (q_cmd),
      .q_pop   (q_pop)
   );

   rc4_back #(.KEY_MAX(KEY_MAX)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_cmd   (q_cmd),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule

>>> dv/rc4_stream_cipher_core_test.sv
// self-checking testbench for the rc4 stream cipher core: key schedules and keystream bytes
module rc4_stream_cipher_core_test;

   localparam int unsigned KEY_LIMIT    = rc4_pkg::KEY_MAX_DEF;
   localparam int          ITEM_TARGET  = 950;
   localparam int          QUIET_LIMIT  = 4000;
   localparam int          DRAIN_CYCLES = 1100;

   typedef struct {
      logic       op;
      logic [7:0] in_byte;
      logic       last_key;
      logic       new_message;
   } req_beat_type;

   logic clock;
   logic reset;

   rc4_req_if req_bus ();
   rc4_rsp_if rsp_bus ();

   rc4_stream_cipher_core #(.KEY_MAX(KEY_LIMIT)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // tracked cipher state
   logic [7:0]  sbox_img [256];
   logic [7:0]  key_mem [256];
   int unsigned key_cnt;
   logic [7:0]  ks_i;
   logic [7:0]  ks_j;

   req_beat_type beat_feed_q[$];
   logic [7:0]   cipher_expect_q[$];
   req_beat_type cur_beat;

   int beats_total;
   int beats_accepted;
   int results_seen;
   int schedules_run;
   int key_drops;
   int fails;
   int feed_gap;
   int calm_feed;
   int rsp_hold;
   int calm_rsp;
   int quiet;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int draw_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // apply one accepted beat to the tracked state, queue the cipher byte for data beats
   task automatic rc4_track(input req_beat_type b);
      logic [7:0]  jj;
      logic [7:0]  tmp;
      logic [7:0]  t;
      int unsigned len;
      if (b.op == rc4_pkg::OP_KEY) begin
         if (key_cnt < KEY_LIMIT) begin
            key_mem[key_cnt[7:0]] = b.in_byte;
            key_cnt++;
         end else begin
            key_drops++;
         end
         if (b.last_key) begin
            len = (key_cnt == 0) ? 1 : key_cnt;
            for (int n = 0; n < 256; n++) sbox_img[n] = n[7:0];
            jj = 8'd0;
            for (int n = 0; n < 256; n++) begin
               jj = jj + sbox_img[n] + key_mem[8'(n % len)];
               tmp = sbox_img[n];
               sbox_img[n] = sbox_img[jj];
               sbox_img[jj] = tmp;
            end
            key_cnt = 0;
            ks_i = 8'd0;
            ks_j = 8'd0;
            schedules_run++;
         end
      end else begin
         if (b.new_message) begin
            ks_i = 8'd0;
            ks_j = 8'd0;
         end
         ks_i = ks_i + 8'd1;
         ks_j = ks_j + sbox_img[ks_i];
         tmp = sbox_img[ks_i];
         sbox_img[ks_i] = sbox_img[ks_j];
         sbox_img[ks_j] = tmp;
         t = sbox_img[ks_i] + sbox_img[ks_j];
         cipher_expect_q.push_back(b.in_byte ^ sbox_img[t]);
      end
   endtask

   task automatic push_beat(input logic op, input logic [7:0] b, input logic lk,
                            input logic nm);
      req_beat_type x;
      x.op = op;
      x.in_byte = b;
      x.last_key = lk;
      x.new_message = nm;
      beat_feed_q.push_back(x);
      beats_total++;
   endtask

   // request driver
   always @(posedge clock) begin : feed_drv
      bit busy;
      if (reset) begin
         req_bus.valid <= 1'b0;
         feed_gap = 0;
      end else begin
         busy = req_bus.valid;
         if (busy && req_bus.ready) begin
            rc4_track(cur_beat);
            beats_accepted++;
            busy = 1'b0;
         end
         if (!busy) begin
            if (feed_gap > 0) begin
               feed_gap--;
            end else if (beat_feed_q.size() > 0) begin
               cur_beat = beat_feed_q.pop_front();
               req_bus.op          <= cur_beat.op;
               req_bus.in_byte     <= cur_beat.in_byte;
               req_bus.last_key    <= cur_beat.last_key;
               req_bus.new_message <= cur_beat.new_message;
               busy = 1'b1;
               if (calm_feed > 0) calm_feed--;
               else if ($urandom_range(0, 19) == 0) calm_feed = $urandom_range(20, 80);
               feed_gap = draw_gap(calm_feed > 0);
            end
         end
         req_bus.valid <= busy;
      end
   end

   // response monitor and stall generator
   always @(posedge clock) begin : rsp_mon
      logic [7:0] want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (cipher_expect_q.size() == 0) begin
               $error("out_byte: expected no beat, actual %02h", rsp_bus.out_byte);
               fails++;
            end else begin
               want = cipher_expect_q.pop_front();
               if (rsp_bus.out_byte !== want) begin
                  $error("out_byte: expected %02h, actual %02h", want, rsp_bus.out_byte);
                  fails++;
               end
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (calm_rsp > 0) calm_rsp--;
            else if ($urandom_range(0, 49) == 0) calm_rsp = $urandom_range(30, 200);
            else if ($urandom_range(0, 5) == 0) rsp_hold = draw_gap(1'b0);
         end
      end
   end

   // stop if no beat moves on either side for too long
   always @(posedge clock) begin : watchdog
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin : main_seq
      int counted;
      int seq;
      int key_len;
      int msgs;
      int len;
      bit close_key;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.op = rc4_pkg::OP_KEY;
      req_bus.in_byte = 8'h00;
      req_bus.last_key = 1'b0;
      req_bus.new_message = 1'b0;
      rsp_bus.ready = 1'b0;
      for (int n = 0; n < 256; n++) begin
         sbox_img[n] = n[7:0];
         key_mem[n] = 8'h00;
      end
      key_cnt = 0;
      ks_i = 8'd0;
      ks_j = 8'd0;

      // data on the identity s-box before any key
      push_beat(rc4_pkg::OP_DATA, 8'h00, 1'b0, 1'b1);
      push_beat(rc4_pkg::OP_DATA, 8'hff, 1'b0, 1'b0);
      push_beat(rc4_pkg::OP_DATA, 8'ha5, 1'b0, 1'b0);
      // single-byte key, new_message set on a key beat is ignored
      push_beat(rc4_pkg::OP_KEY, 8'hff, 1'b1, 1'b1);
      push_beat(rc4_pkg::OP_DATA, 8'h00, 1'b0, 1'b1);
      push_beat(rc4_pkg::OP_DATA, 8'hff, 1'b0, 1'b0);
      // all-zero key; last_key on a data beat is ignored
      push_beat(rc4_pkg::OP_KEY, 8'h00, 1'b0, 1'b0);
      push_beat(rc4_pkg::OP_KEY, 8'h00, 1'b0, 1'b0);
      push_beat(rc4_pkg::OP_KEY, 8'h00, 1'b1, 1'b0);
      push_beat(rc4_pkg::OP_DATA, 8'h5a, 1'b0, 1'b1);
      push_beat(rc4_pkg::OP_DATA, 8'hff, 1'b1, 1'b0);
      // five-byte key, then a message and a restart
      push_beat(rc4_pkg::OP_KEY, 8'h01, 1'b0, 1'b0);
      push_beat(rc4_pkg::OP_KEY, 8'h23, 1'b0, 1'b0);
      push_beat(rc4_pkg::OP_KEY, 8'h45, 1'b0, 1'b0);
      push_beat(rc4_pkg::OP_KEY, 8'h67, 1'b0, 1'b0);
      push_beat(rc4_pkg::OP_KEY, 8'h89, 1'b1, 1'b0);
      push_beat(rc4_pkg::OP_DATA, 8'h00, 1'b0, 1'b1);
      push_beat(rc4_pkg::OP_DATA, 8'h00, 1'b0, 1'b0);
      push_beat(rc4_pkg::OP_DATA, 8'h80, 1'b0, 1'b1);

      // rekey then messages; first two keys overfill and exactly fill the store
      counted = beats_total;
      seq = 0;
      while (counted < ITEM_TARGET) begin
         if (seq == 0) key_len = KEY_LIMIT + 2;
         else if (seq == 1) key_len = KEY_LIMIT;
         else if ($urandom_range(0, 49) == 0) key_len = $urandom_range(250, 262);
         else if ($urandom_range(0, 4) != 0) key_len = $urandom_range(1, 16);
         else key_len = 0;
         // a key left open runs into the next schedule
         close_key = (seq < 2) || ($urandom_range(0, 11) != 0);
         for (int n = 0; n < key_len; n++) begin
            push_beat(rc4_pkg::OP_KEY, 8'($urandom_range(0, 255)),
                      close_key && (n == key_len - 1), $urandom_range(0, 3) == 0);
            if (n < KEY_LIMIT) counted++;
         end
         msgs = $urandom_range(1, 3);
         for (int m = 0; m < msgs; m++) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
            for (int n = 0; n < len; n++) begin
               push_beat(rc4_pkg::OP_DATA, 8'($urandom_range(0, 255)),
                         $urandom_range(0, 7) == 0,
                         (n == 0) ? ($urandom_range(0, 6) != 0) : ($urandom_range(0, 24) == 0));
               counted++;
            end
         end
         seq++;
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (!(beats_accepted == beats_total && cipher_expect_q.size() == 0))
         @(posedge clock);
      // a trailing key schedule may still be running
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d beats over %0d key sequences: %0d schedules, %0d dropped key bytes",
               beats_total, seq, schedules_run, key_drops);
      $display("checked %0d cipher bytes, %0d mismatches", results_seen, fails);
      if (fails == 0 && cipher_expect_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/rc4_pkg.sv
hw/rtl/rc4_req_if.sv
hw/rtl/rc4_rsp_if.sv
hw/rtl/rc4_ram.sv
hw/rtl/rc4_front.sv
hw/rtl/rc4_back.sv
hw/rtl/rc4_stream_cipher_core.sv
dv/rc4_stream_cipher_core_test.sv
